>>> rtl/core/psd_pkg.sv
// Shared widths, payload structs and helpers for the point to segment distance block.
`timescale 1ns / 1ps
package psd_pkg;

    localparam int CB       = 16;          // coordinate width
    localparam int DW       = CB + 1;      // coordinate difference width
    localparam int PW       = 2 * DW;      // product of two differences
    localparam int LW       = 2 * CB + 2;  // squared length
    localparam int DOT_W    = LW + 1;      // signed dot product
    localparam int AF       = 16;          // projection fraction bits
    localparam int QW       = AF + 1;      // projection, unsigned Q1.16
    localparam int NW       = LW + QW;     // dividend width
    localparam int FW       = QW + 1 + DW; // projection times difference
    localparam int FTW      = CB + 2;      // foot arithmetic width
    localparam int RW       = CB + 1;      // point to foot difference
    localparam int SUM_W    = 2 * RW;      // sum of squares
    localparam int DIST_W   = SUM_W / 2;   // root width
    localparam int SQ_REM_W = DIST_W + 2;  // root remainder width
    localparam int NREG     = 6;
    localparam int AW       = 5;
    localparam int IDX_W    = 3;

    localparam logic [IDX_W-1:0] REG_START_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_START_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_START_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_END_X   = 3'd3;
    localparam logic [IDX_W-1:0] REG_END_Y   = 3'd4;
    localparam logic [IDX_W-1:0] REG_END_Z   = 3'd5;

    typedef struct packed {
        logic          coll;
        logic          lo;
        logic          hi;
        logic [CB-1:0] px;
        logic [CB-1:0] py;
        logic [CB-1:0] pz;
        logic [QW-1:0] q;
        logic [LW-1:0] rem;
        logic [QW-1:0] num;
    } t_div_item;

    typedef struct packed {
        logic                coll;
        logic                clamped;
        logic [SQ_REM_W-1:0] rem;
        logic [DIST_W-1:0]   root;
        logic [SUM_W-1:0]    n;
    } t_sqrt_item;

    function automatic logic signed [FTW-1:0] sext_ft(input logic [CB-1:0] v);
        return $signed({{(FTW-CB){v[CB-1]}}, v});
    endfunction

endpackage

>>> rtl/core/psd_div_cell.sv
// One restoring division cell: produces one projection bit per item.
`timescale 1ns / 1ps
module psd_div_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  psd_pkg::t_div_item   i_item,
    input  logic [psd_pkg::LW-1:0] i_len2,
    output logic                 o_valid,
    output psd_pkg::t_div_item   o_item
);

    logic                   r_valid;
    psd_pkg::t_div_item     r_item;
    psd_pkg::t_div_item     n_item;
    logic [psd_pkg::LW:0]   rem2;
    logic [psd_pkg::LW:0]   diff;
    logic                   ge;

    always_comb begin
        rem2   = {i_item.rem, i_item.num[psd_pkg::QW-1]};
        diff   = rem2 - {1'b0, i_len2};
        ge     = rem2 >= {1'b0, i_len2};
        n_item = i_item;
        n_item.rem = ge ? diff[psd_pkg::LW-1:0] : rem2[psd_pkg::LW-1:0];
        n_item.num = {i_item.num[psd_pkg::QW-2:0], 1'b0};
        n_item.q   = {i_item.q[psd_pkg::QW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> rtl/core/psd_sqrt_cell.sv
// One digit-by-digit square root cell: produces one root bit per item.
`timescale 1ns / 1ps
module psd_sqrt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  psd_pkg::t_sqrt_item i_item,
    output logic                o_valid,
    output psd_pkg::t_sqrt_item o_item
);

    logic                          r_valid;
    psd_pkg::t_sqrt_item           r_item;
    psd_pkg::t_sqrt_item           n_item;
    logic [psd_pkg::SQ_REM_W+1:0]  rem2;
    logic [psd_pkg::SQ_REM_W+1:0]  trial;
    logic [psd_pkg::SQ_REM_W+1:0]  diff;
    logic                          ge;

    always_comb begin
        rem2   = {i_item.rem, i_item.n[psd_pkg::SUM_W-1 -: 2]};
        trial  = {2'b00, i_item.root, 2'b01};
        diff   = rem2 - trial;
        ge     = rem2 >= trial;
        n_item = i_item;
        n_item.rem  = ge ? diff[psd_pkg::SQ_REM_W-1:0] : rem2[psd_pkg::SQ_REM_W-1:0];
        n_item.root = {i_item.root[psd_pkg::DIST_W-2:0], ge};
        n_item.n    = {i_item.n[psd_pkg::SUM_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> rtl/core/point_segment_distance_3d.sv
// Top level: config registers, projection pipeline, divider and root cell chains, output skid.
//
//  channel   dir   transfer on             payload
//  s_axis    in    i_s_tvalid&o_s_tready   tdata: point_x, point_y, point_z
//  m_axis    out   o_m_tvalid&i_m_tready   tdata: distance; tuser: degenerate, foot_clamped
//  apb       in    psel&penable&pwrite     six 16-bit segment endpoint registers
//
//  One point per cycle while the output is not stalled; the path runs through 4 front stages,
//  17 divider cells, 4 middle stages, 17 root cells and the output register.
//  Reset clears all valid bits; the segment registers reset to zero (degenerate).
//  A stalled output fills the skid register; input ready drops only while it is full.
`timescale 1ns / 1ps
module point_segment_distance_3d (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [47:0]             i_s_tdata,   // [15:0] point_x, [31:16] point_y, [47:32] point_z
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [23:0]             o_m_tdata,   // [16:0] distance, zero fill above
    output logic [1:0]              o_m_tuser,   // [0] degenerate, [1] foot_clamped
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [psd_pkg::AW-1:0]  paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int CB = psd_pkg::CB;
    localparam logic signed [psd_pkg::FW-1:0] ROUND_HALF = psd_pkg::FW'(1 << (psd_pkg::AF - 1));
    localparam logic [psd_pkg::DIST_W-1:0] DIST_ONES = '1;

    // configuration
    logic [CB-1:0]                   r_cfg [psd_pkg::NREG];
    logic [psd_pkg::IDX_W-1:0]       cfg_idx;
    logic signed [psd_pkg::DW-1:0]   r_d [3];
    logic [psd_pkg::LW-1:0]          r_len2;
    logic                            collapsed;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[psd_pkg::AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < psd_pkg::NREG; i++) r_cfg[i] <= '0;
        end else if (psel && penable && pwrite && pready &&
                     cfg_idx < psd_pkg::IDX_W'(psd_pkg::NREG)) begin
            r_cfg[cfg_idx] <= pwdata[CB-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (cfg_idx < psd_pkg::IDX_W'(psd_pkg::NREG)) prdata = 32'(r_cfg[cfg_idx]);
    end

    assign collapsed = r_cfg[psd_pkg::REG_START_X] == r_cfg[psd_pkg::REG_END_X] &&
                       r_cfg[psd_pkg::REG_START_Y] == r_cfg[psd_pkg::REG_END_Y] &&
                       r_cfg[psd_pkg::REG_START_Z] == r_cfg[psd_pkg::REG_END_Z];

    // direction and squared length are registered from the segment registers, r_d first and r_len2 from r_d
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_d[i] <= psd_pkg::DW'(psd_pkg::sext_ft(r_cfg[i + 3]) -
                                   psd_pkg::sext_ft(r_cfg[i]));
        end
        r_len2 <= psd_pkg::LW'(r_d[0] * r_d[0]) + psd_pkg::LW'(r_d[1] * r_d[1]) +
                  psd_pkg::LW'(r_d[2] * r_d[2]);
    end

    // flow control
    logic adv;
    logic r_out_v, r_skid_v;
    assign adv        = !r_skid_v;
    assign o_s_tready = adv;

    // stage A: capture point
    logic          r_a_v, r_a_coll;
    logic [CB-1:0] r_a_p [3];
    // stage B: products of point offset and direction
    logic                          r_b_v, r_b_coll;
    logic [CB-1:0]                 r_b_p [3];
    logic signed [psd_pkg::PW-1:0] r_b_prod [3];
    // stage C: dot product
    logic                             r_c_v, r_c_coll;
    logic [CB-1:0]                    r_c_p [3];
    logic signed [psd_pkg::DOT_W-1:0] r_c_dot;
    // stage D: clamp decision and dividend
    logic               r_dd_v;
    psd_pkg::t_div_item r_dd_item;

    logic signed [psd_pkg::DW-1:0]    w [3];
    logic signed [psd_pkg::DOT_W-1:0] dot;
    logic [psd_pkg::NW-1:0]           num;
    psd_pkg::t_div_item               dd_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w[i] = psd_pkg::DW'(psd_pkg::sext_ft(r_a_p[i]) - psd_pkg::sext_ft(r_cfg[i]));
        end
        dot = psd_pkg::DOT_W'(r_b_prod[0]) + psd_pkg::DOT_W'(r_b_prod[1]) +
              psd_pkg::DOT_W'(r_b_prod[2]);
        num = psd_pkg::NW'({r_c_dot[psd_pkg::LW-1:0], {psd_pkg::AF{1'b0}}}) +
              psd_pkg::NW'(r_len2 >> 1);
        dd_next.coll = r_c_coll;
        dd_next.lo   = r_c_dot[psd_pkg::DOT_W-1];
        dd_next.hi   = r_c_dot > $signed({1'b0, r_len2});
        dd_next.px   = r_c_p[0];
        dd_next.py   = r_c_p[1];
        dd_next.pz   = r_c_p[2];
        dd_next.q    = '0;
        dd_next.rem  = num[psd_pkg::NW-1:psd_pkg::QW];
        dd_next.num  = num[psd_pkg::QW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v  <= 1'b0;
            r_b_v  <= 1'b0;
            r_c_v  <= 1'b0;
            r_dd_v <= 1'b0;
        end else if (adv) begin
            r_a_v  <= i_s_tvalid;
            r_b_v  <= r_a_v;
            r_c_v  <= r_b_v;
            r_dd_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_p[0] <= i_s_tdata[15:0];
            r_a_p[1] <= i_s_tdata[31:16];
            r_a_p[2] <= i_s_tdata[47:32];
            r_a_coll <= collapsed;
            for (int i = 0; i < 3; i++) begin
                r_b_prod[i] <= w[i] * r_d[i];
            end
            r_b_p     <= r_a_p;
            r_b_coll  <= r_a_coll;
            r_c_dot   <= dot;
            r_c_p     <= r_b_p;
            r_c_coll  <= r_b_coll;
            r_dd_item <= dd_next;
        end
    end

    // divider chain, one quotient bit per cell
    logic               div_v    [psd_pkg::QW+1];
    psd_pkg::t_div_item div_item [psd_pkg::QW+1];
    assign div_v[0]    = r_dd_v;
    assign div_item[0] = r_dd_item;

    for (genvar g = 0; g < psd_pkg::QW; g++) begin : g_div
        psd_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (div_v[g]),
            .i_item  (div_item[g]),
            .i_len2  (r_len2),
            .o_valid (div_v[g+1]),
            .o_item  (div_item[g+1])
        );
    end

    // stage E: projection times direction
    logic                          r_e_v, r_e_coll, r_e_lo, r_e_hi;
    logic [CB-1:0]                 r_e_p [3];
    logic signed [psd_pkg::FW-1:0] r_e_prod [3];
    // stage F: point minus foot
    logic                          r_f_v, r_f_coll, r_f_clamped;
    logic signed [psd_pkg::RW-1:0] r_f_r [3];
    // stage G: squares
    logic                          r_g_v, r_g_coll, r_g_clamped;
    logic [psd_pkg::SUM_W-1:0]     r_g_sq [3];
    // stage H: sum of squares into the root chain
    logic                          r_h_v;
    psd_pkg::t_sqrt_item           r_h_item;

    psd_pkg::t_div_item                div_last;
    logic [CB-1:0]                     p_last [3];
    logic signed [psd_pkg::FW-1:0]     rnd [3];
    logic signed [psd_pkg::FW-1:0]     sh [3];
    logic signed [psd_pkg::FTW-1:0]    foot [3];
    logic signed [psd_pkg::FTW-1:0]    diff [3];
    logic signed [psd_pkg::SUM_W-1:0]  sq [3];
    psd_pkg::t_sqrt_item               h_next;

    always_comb begin
        div_last  = div_item[psd_pkg::QW];
        p_last[0] = div_last.px;
        p_last[1] = div_last.py;
        p_last[2] = div_last.pz;
        for (int i = 0; i < 3; i++) begin
            rnd[i] = r_e_prod[i] + ROUND_HALF;
            sh[i]  = rnd[i] >>> psd_pkg::AF;
            if (r_e_lo) begin
                foot[i] = psd_pkg::sext_ft(r_cfg[i]);
            end else if (r_e_hi) begin
                foot[i] = psd_pkg::sext_ft(r_cfg[i + 3]);
            end else begin
                foot[i] = psd_pkg::sext_ft(r_cfg[i]) + sh[i][psd_pkg::FTW-1:0];
            end
            diff[i] = psd_pkg::sext_ft(r_e_p[i]) - foot[i];
            sq[i]   = r_f_r[i] * r_f_r[i];
        end
        h_next.coll    = r_g_coll;
        h_next.clamped = r_g_clamped;
        h_next.rem     = '0;
        h_next.root    = '0;
        h_next.n       = r_g_sq[0] + r_g_sq[1] + r_g_sq[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
        end else if (adv) begin
            r_e_v <= div_v[psd_pkg::QW];
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_e_prod[i] <= $signed({1'b0, div_last.q}) * r_d[i];
                r_f_r[i]    <= diff[i][psd_pkg::RW-1:0];
                r_g_sq[i]   <= sq[i];
            end
            r_e_p       <= p_last;
            r_e_coll    <= div_last.coll;
            r_e_lo      <= div_last.lo;
            r_e_hi      <= div_last.hi;
            r_f_coll    <= r_e_coll;
            r_f_clamped <= r_e_lo || r_e_hi;
            r_g_coll    <= r_f_coll;
            r_g_clamped <= r_f_clamped;
            r_h_item    <= h_next;
        end
    end

    // square root chain, one root bit per cell
    logic                sq_v    [psd_pkg::DIST_W+1];
    psd_pkg::t_sqrt_item sq_item [psd_pkg::DIST_W+1];
    assign sq_v[0]    = r_h_v;
    assign sq_item[0] = r_h_item;

    for (genvar g = 0; g < psd_pkg::DIST_W; g++) begin : g_sqrt
        psd_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (sq_v[g]),
            .i_item  (sq_item[g]),
            .o_valid (sq_v[g+1]),
            .o_item  (sq_item[g+1])
        );
    end

    // rounding, saturation, sentinel
    psd_pkg::t_sqrt_item     sq_last;
    logic [psd_pkg::DIST_W:0] rounded;
    logic [psd_pkg::DIST_W-1:0] dist_new;
    logic [1:0]              user_new;
    logic                    push, take;

    always_comb begin
        sq_last = sq_item[psd_pkg::DIST_W];
        rounded = {1'b0, sq_last.root} +
                  (psd_pkg::DIST_W + 1)'(sq_last.rem >
                                         psd_pkg::SQ_REM_W'(sq_last.root));
        if (sq_last.coll) begin
            dist_new = DIST_ONES;
            user_new = 2'b01;
        end else begin
            dist_new = (rounded >= {1'b0, DIST_ONES}) ? DIST_ONES - 1'b1 :
                       rounded[psd_pkg::DIST_W-1:0];
            user_new = {sq_last.clamped, 1'b0};
        end
    end

    assign push = sq_v[psd_pkg::DIST_W] && adv;
    assign take = r_out_v && i_m_tready;

    logic [psd_pkg::DIST_W-1:0] r_out_dist, r_skid_dist;
    logic [1:0]                 r_out_user, r_skid_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (take || !r_out_v) begin
            r_out_v  <= r_skid_v || push;
            r_skid_v <= 1'b0;
        end else if (push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_out_v) begin
            if (r_skid_v) begin
                r_out_dist <= r_skid_dist;
                r_out_user <= r_skid_user;
            end else begin
                r_out_dist <= dist_new;
                r_out_user <= user_new;
            end
        end else if (push) begin
            r_skid_dist <= dist_new;
            r_skid_user <= user_new;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = 24'(r_out_dist);
    assign o_m_tuser  = r_out_user;

    // skid register only ever holds a transfer behind a waiting output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v) else $error("skid holds data with empty output");

    // a degenerate result carries the sentinel and no clamp flag
    a_degen_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_user[0]) |-> (r_out_dist == DIST_ONES && !r_out_user[1]))
        else $error("degenerate result without sentinel");

    // a real distance never collides with the sentinel
    a_no_false_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_user[0]) |-> (r_out_dist != DIST_ONES))
        else $error("distance equals sentinel");

    // the pipeline never pushes into a full skid register
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !push) else $error("result lost at output");

endmodule

>>> tb/point_segment_distance_3d_tb.sv
// Self-checking testbench for the 3D point to segment distance block.
`timescale 1ns / 1ps
module point_segment_distance_3d_tb;

    localparam logic [psd_pkg::IDX_W-1:0] REG_SPARE_A = 3'd6;  // unmapped, writes ignored
    localparam logic [psd_pkg::IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam logic [16:0]      DIST_SENTINEL = 17'h1ffff;

    typedef struct packed {
        logic [16:0] dval;
        logic        degen;
        logic        clamped;
    } t_dist_res;

    typedef struct {
        int          seg;
        logic [15:0] px, py, pz;
        bit          known;
        t_dist_res   res;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;    // [15:0] point_x, [31:16] point_y, [47:32] point_z
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;    // [16:0] distance, zero fill above
    logic [1:0]  o_m_tuser;    // [0] degenerate, [1] foot_clamped
    logic        psel, penable, pwrite;
    logic [psd_pkg::AW-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    point_segment_distance_3d u_top (.*);

    logic [15:0] seg_regs [psd_pkg::NREG];
    t_dist_res   expected_dist_q [$];
    int          errors;
    int          mismatches;
    int          burst_left;
    bit          use_gaps;
    int          hold_left;
    int          cur_seg;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL point_segment_distance_3d");
        $finish;
    end

    function automatic longint sx(input logic [15:0] v);
        return longint'($signed(v));
    endfunction

    function automatic t_dist_res predict_distance(input logic [15:0] px, py, pz);
        t_dist_res    r;
        longint       s [3], d [3], p [3], foot [3];
        longint       len2, dot, alpha, prod, diff;
        longint unsigned sum, root, bitv, rem;
        r = '0;
        if (seg_regs[0] == seg_regs[3] && seg_regs[1] == seg_regs[4] &&
            seg_regs[2] == seg_regs[5]) begin
            r.dval  = DIST_SENTINEL;
            r.degen = 1'b1;
            return r;
        end
        p[0] = sx(px); p[1] = sx(py); p[2] = sx(pz);
        len2 = 0; dot = 0;
        for (int i = 0; i < 3; i++) begin
            s[i] = sx(seg_regs[i]);
            d[i] = sx(seg_regs[i+3]) - s[i];
            len2 += d[i] * d[i];
            dot  += (p[i] - s[i]) * d[i];
        end
        if (dot < 0) begin
            r.clamped = 1'b1;
            for (int i = 0; i < 3; i++) foot[i] = s[i];
        end else if (dot > len2) begin
            r.clamped = 1'b1;
            for (int i = 0; i < 3; i++) foot[i] = s[i] + d[i];
        end else begin
            alpha = ((dot <<< psd_pkg::AF) + (len2 >>> 1)) / len2;
            for (int i = 0; i < 3; i++) begin
                prod    = alpha * d[i] + (longint'(1) <<< (psd_pkg::AF - 1));
                foot[i] = s[i] + (prod >>> psd_pkg::AF);   // arithmetic shift floors
            end
        end
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            diff = p[i] - foot[i];
            sum += longint'(diff * diff);
        end
        root = 0; rem = sum; bitv = 64'd1 << 62;
        while (bitv > sum) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        if (rem > root) root++;
        if (root >= 64'h1ffff) root = 64'h1fffe;
        r.dval = root[16:0];
        return r;
    endfunction

    // APB write; called and returns at a falling edge
    task automatic reg_write(input logic [psd_pkg::IDX_W-1:0] idx, input logic [15:0] value);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = {16'($urandom_range(0, 65535)), value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx < psd_pkg::NREG) seg_regs[idx] = value;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic wait_idle();
        i_s_tvalid = 1'b0;
        while (expected_dist_q.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic load_segment(input logic [15:0] v [6]);
        wait_idle();
        for (int i = 0; i < psd_pkg::NREG; i++) reg_write(psd_pkg::IDX_W'(i), v[i]);
    endtask

    task automatic send_point(input logic [15:0] x, y, z, input bit known,
                              input t_dist_res res);
        if (burst_left == 0) begin
            if (use_gaps) begin
                i_s_tvalid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            burst_left = int'($urandom_range(1, 20));
        end
        burst_left--;
        i_s_tvalid = 1'b1;
        i_s_tdata  = {z, y, x};
        do @(posedge i_clk); while (!o_s_tready);
        expected_dist_q.push_back(known ? res : predict_distance(x, y, z));
        @(negedge i_clk);
    endtask

    // receiver: long hold when requested, else a rotating stall pattern
    initial begin
        int cyc;
        cyc = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (hold_left > 0) begin
                i_m_tready = 1'b0;
                hold_left--;
            end else begin
                case ((cyc / 64) % 3)
                    0: i_m_tready = 1'b1;
                    1: i_m_tready = 1'($urandom_range(0, 1));
                    default: i_m_tready = (cyc % 4 == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_dist_res want, got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata[16:0], o_m_tuser[0], o_m_tuser[1]};
            if (expected_dist_q.size() == 0) begin
                errors++;
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer: %p", got);
            end else begin
                want = expected_dist_q.pop_front();
                if (got !== want || o_m_tdata[23:17] !== '0) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp dist %0d deg %b clamp %b, %s %0d deg %b clamp %b",
                                 want.dval, want.degen, want.clamped, "got dist",
                                 got.dval, got.degen, got.clamped);
                end
            end
        end
    end

    logic [15:0] seg_set [5][6];
    t_stim_row   rows [$];

    initial begin
        logic [15:0] v [6];
        logic [15:0] x, y, z;
        int          t, n;
        errors = 0; mismatches = 0; burst_left = 0; use_gaps = 1'b1; hold_left = 0;
        i_rst_n = 1'b0; i_s_tvalid = 1'b0; i_s_tdata = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        for (int i = 0; i < psd_pkg::NREG; i++) seg_regs[i] = '0;

        seg_set[0] = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};        // reset state
        seg_set[1] = '{16'd0, 16'd0, 16'd0, 16'd160, 16'd0, 16'd0};
        seg_set[2] = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff};
        seg_set[3] = '{16'd100, -16'sd50, 16'd7, -16'sd300, 16'd20, 16'd900};
        seg_set[4] = '{16'd1234, -16'sd5, 16'd77, 16'd1234, -16'sd5, 16'd77}; // S == E

        // degenerate segment after reset
        rows.push_back('{0, 16'd0, 16'd0, 16'd0, 1, '{DIST_SENTINEL, 1'b1, 1'b0}});
        rows.push_back('{0, 16'h7fff, 16'h8000, 16'd5, 1, '{DIST_SENTINEL, 1'b1, 1'b0}});
        // segment along x from 0 to 160: interior, both ends, both clamps
        rows.push_back('{1, 16'd0, 16'd0, 16'd0, 1, '{17'd0, 1'b0, 1'b0}});
        rows.push_back('{1, 16'd80, 16'd0, 16'd0, 1, '{17'd0, 1'b0, 1'b0}});
        rows.push_back('{1, 16'd80, 16'd48, 16'd0, 1, '{17'd48, 1'b0, 1'b0}});
        rows.push_back('{1, 16'd80, 16'd0, -16'sd64, 1, '{17'd64, 1'b0, 1'b0}});
        rows.push_back('{1, 16'd160, 16'd0, 16'd0, 1, '{17'd0, 1'b0, 1'b0}});
        rows.push_back('{1, -16'sd16, 16'd0, 16'd0, 1, '{17'd16, 1'b0, 1'b1}});
        rows.push_back('{1, 16'd176, 16'd0, 16'd0, 1, '{17'd16, 1'b0, 1'b1}});
        rows.push_back('{1, 16'h8000, 16'h7fff, 16'h8000, 0, '0});
        // diagonal over the full range
        rows.push_back('{2, 16'h8000, 16'h8000, 16'h8000, 1, '{17'd0, 1'b0, 1'b0}});
        rows.push_back('{2, 16'h7fff, 16'h7fff, 16'h7fff, 1, '{17'd0, 1'b0, 1'b0}});
        rows.push_back('{2, 16'h7fff, 16'h8000, 16'h7fff, 0, '0});
        rows.push_back('{2, 16'h8000, 16'h7fff, 16'h8000, 0, '0});
        rows.push_back('{2, 16'h8000, 16'h8000, 16'h7fff, 0, '0});
        rows.push_back('{2, 16'd0, 16'd0, 16'd0, 0, '0});
        rows.push_back('{3, 16'd0, 16'd0, 16'd0, 0, '0});
        rows.push_back('{3, 16'hffff, 16'h0001, 16'h1234, 0, '0});
        rows.push_back('{3, -16'sd100, -16'sd15, 16'd453, 0, '0});
        rows.push_back('{3, 16'h7fff, 16'h7fff, 16'h7fff, 0, '0});
        rows.push_back('{4, 16'd1234, -16'sd5, 16'd77, 1, '{DIST_SENTINEL, 1'b1, 1'b0}});
        rows.push_back('{4, 16'h8000, 16'h8000, 16'h8000, 1, '{DIST_SENTINEL, 1'b1, 1'b0}});

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        cur_seg = 0;
        foreach (rows[k]) begin
            if (rows[k].seg != cur_seg) begin
                load_segment(seg_set[rows[k].seg]);
                cur_seg = rows[k].seg;
            end
            send_point(rows[k].px, rows[k].py, rows[k].pz, rows[k].known, rows[k].res);
        end

        // writes to unmapped indexes must not disturb the segment
        wait_idle();
        reg_write(REG_SPARE_A, 16'h0000);
        reg_write(REG_SPARE_B, 16'hffff);
        send_point(16'd40, 16'd3, 16'd600, 0, '0);
        send_point(16'h8000, 16'h7fff, 16'h0000, 0, '0);

        for (int ph = 0; ph < 7; ph++) begin
            for (int i = 0; i < 3; i++) begin
                case ($urandom_range(0, 3))
                    0: v[i] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                    1: v[i] = 16'($urandom_range(0, 255) - 128);
                    default: v[i] = 16'($urandom_range(0, 65535));
                endcase
                case ($urandom_range(0, 3))
                    0: v[i+3] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                    1: v[i+3] = 16'(v[i] + $urandom_range(0, 31) - 16);
                    default: v[i+3] = 16'($urandom_range(0, 65535));
                endcase
            end
            if (ph == 3) for (int i = 0; i < 3; i++) v[i+3] = v[i];
            load_segment(v);
            use_gaps = (ph != 5);
            if (ph == 2) hold_left = 300;  // input must back up behind the stalled output
            n = int'($urandom_range(75, 95));
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 2) == 0) begin
                    x = 16'($urandom_range(0, 65535));
                    y = 16'($urandom_range(0, 65535));
                    z = 16'($urandom_range(0, 65535));
                end else begin
                    // points around the segment, with some beyond either end
                    t = int'($urandom_range(0, 320)) - 32;
                    x = 16'(sx(v[0]) + (sx(v[3]) - sx(v[0])) * t / 256
                            + int'($urandom_range(0, 512)) - 256);
                    y = 16'(sx(v[1]) + (sx(v[4]) - sx(v[1])) * t / 256
                            + int'($urandom_range(0, 512)) - 256);
                    z = 16'(sx(v[2]) + (sx(v[5]) - sx(v[2])) * t / 256
                            + int'($urandom_range(0, 512)) - 256);
                end
                send_point(x, y, z, 0, '0);
            end
        end

        i_s_tvalid = 1'b0;
        t = 0;
        while (expected_dist_q.size() != 0 && t < 20000) begin
            @(negedge i_clk);
            t++;
        end
        if (expected_dist_q.size() != 0) errors++;
        repeat (60) @(negedge i_clk);
        if (errors == 0)
            $display("PASS point_segment_distance_3d");
        else
            $display("FAIL point_segment_distance_3d");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/psd_pkg.sv
rtl/core/psd_div_cell.sv
rtl/core/psd_sqrt_cell.sv
rtl/core/point_segment_distance_3d.sv
tb/point_segment_distance_3d_tb.sv
